/* design/slls_pkg.sv */
package slls_pkg;

   // default depth of the label name store
   localparam int NAME_MAX_DEF = 32;

   // widest name store address any legal depth needs
   localparam int MEM_AW = 6;

   // script characters
   localparam logic [7:0] DECODE_KEY = 8'h84;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // result kinds
   localparam logic [1:0] KIND_LINE  = 2'd0;
   localparam logic [1:0] KIND_NAME  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_TILDE = 2'd3;

   // register byte address width; address bit 2 selects the register index
   localparam int CSR_AW = 3;
   localparam logic REG_DECODE = 1'b0;

   // name store access from the controller
   typedef struct packed {
      logic              wr_en;
      logic [MEM_AW-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [MEM_AW-1:0] rd_addr;
   } mem_req_type;

endpackage

/* design/slls_if.sv */
interface slls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface slls_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  name_char;
   logic [31:0] line_number;
   logic [31:0] byte_offset;
   logic [5:0]  name_length;
   logic        name_truncated;
   logic        last;

   modport source (output valid, output kind, output name_char, output line_number,
                   output byte_offset, output name_length, output name_truncated,
                   output last, input ready);
   modport sink (input valid, input kind, input name_char, input line_number,
                 input byte_offset, input name_length, input name_truncated,
                 input last, output ready);
endinterface

/* design/slls_name_ram.sv */
module slls_name_ram #(
   parameter int NAME_MAX = slls_pkg::NAME_MAX_DEF
) (
   input  logic                 clock,
   input  slls_pkg::mem_req_type mem_req,
   output logic [7:0]           rd_data
);

   localparam int ADDR_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

   logic [7:0] mem [NAME_MAX];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[ADDR_W-1:0]] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/slls_ctrl.sv */
module slls_ctrl #(
   parameter int NAME_MAX = slls_pkg::NAME_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  decode_enable,
   slls_req_if.sink              req,
   slls_rsp_if.source            rsp,
   output slls_pkg::mem_req_type mem_req,
   input  logic [7:0]            rd_data
);

   localparam int CNT_W = $clog2(NAME_MAX + 1);

   // scan modes
   localparam logic [2:0] MODE_TOP   = 3'd0;
   localparam logic [2:0] MODE_STAR  = 3'd1;
   localparam logic [2:0] MODE_NAME  = 3'd2;
   localparam logic [2:0] MODE_DROP  = 3'd3;
   localparam logic [2:0] MODE_SKIP  = 3'd4;
   localparam logic [2:0] MODE_TILDE = 3'd5;

   // emit sequencer
   localparam logic [2:0] SEQ_IDLE  = 3'd0;
   localparam logic [2:0] SEQ_NAME  = 3'd1;
   localparam logic [2:0] SEQ_END   = 3'd2;
   localparam logic [2:0] SEQ_TILDE = 3'd3;
   localparam logic [2:0] SEQ_LINE  = 3'd4;

   logic [2:0]       mode_ff, mode_in;
   logic [2:0]       seq_ff, seq_in;
   logic [31:0]      line_ff, line_in;
   logic [31:0]      off_ff, off_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] emit_len_ff, emit_len_in;
   logic             emit_ovf_ff, emit_ovf_in;

   logic             rsp_valid_ff;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       char_ff, char_in;
   logic [31:0]      oline_ff, oline_in;
   logic [31:0]      ooff_ff, ooff_in;
   logic [5:0]       olen_ff, olen_in;
   logic             otrunc_ff, otrunc_in;
   logic             olast_ff, olast_in;
   logic             out_load;

   logic [7:0]       c;
   logic             acc, blank, is_nl, label_nl, out_free;
   logic [31:0]      line_inc, off_inc;
   logic [CNT_W-1:0] idx_nxt;

   assign c        = req.byte_in ^ (decode_enable ? slls_pkg::DECODE_KEY : 8'h00);
   assign req.ready = (seq_ff == SEQ_IDLE);
   assign acc      = req.valid && req.ready;
   assign blank    = (c == slls_pkg::CHAR_SPACE) || (c == slls_pkg::CHAR_TAB);
   assign is_nl    = (c == slls_pkg::CHAR_NL);
   assign line_inc = (line_ff == '1) ? line_ff : line_ff + 32'd1;
   assign off_inc  = (off_ff == '1) ? off_ff : off_ff + 32'd1;
   assign label_nl = ((mode_ff == MODE_STAR) || (mode_ff == MODE_NAME) ||
                      (mode_ff == MODE_DROP)) && (fill_ff != '0);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign idx_nxt  = idx_ff + 1'b1;

   // line parser and name store writes
   always_comb begin
      mode_in         = mode_ff;
      line_in         = line_ff;
      off_in          = off_ff;
      fill_in         = fill_ff;
      ovf_in          = ovf_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = slls_pkg::MEM_AW'(fill_ff);
      mem_req.wr_data = c;
      if (acc) begin
         off_in = off_inc;
         if (is_nl) begin
            line_in = line_inc;
            mode_in = MODE_TOP;
            fill_in = '0;
            ovf_in  = 1'b0;
         end else begin
            unique case (mode_ff)
               MODE_TOP: begin
                  if (!blank) begin
                     priority if (c == slls_pkg::CHAR_STAR) begin
                        fill_in = '0;
                        ovf_in  = 1'b0;
                        mode_in = MODE_STAR;
                     end else if (c == slls_pkg::CHAR_TILDE) begin
                        mode_in = MODE_TILDE;
                     end else begin
                        mode_in = MODE_SKIP;
                     end
                  end
               end
               MODE_STAR, MODE_NAME: begin
                  if (blank) begin
                     if (mode_ff == MODE_NAME) begin
                        mode_in = MODE_DROP;
                     end
                  end else begin
                     mode_in = MODE_NAME;
                     if (fill_ff < CNT_W'(NAME_MAX)) begin
                        mem_req.wr_en = 1'b1;
                        fill_in       = fill_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
               end
               MODE_DROP, MODE_SKIP, MODE_TILDE: begin
               end
               default: begin
                  mode_in = MODE_SKIP;
               end
            endcase
         end
      end
   end

   // result sequencer
   always_comb begin
      seq_in          = seq_ff;
      idx_in          = idx_ff;
      emit_len_in     = emit_len_ff;
      emit_ovf_in     = emit_ovf_ff;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = slls_pkg::MEM_AW'(idx_nxt);
      out_load        = 1'b0;
      kind_in         = slls_pkg::KIND_LINE;
      char_in         = 8'h00;
      oline_in        = 32'd0;
      ooff_in         = 32'd0;
      olen_in         = 6'd0;
      otrunc_in       = 1'b0;
      olast_in        = 1'b0;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (acc && is_nl) begin
               emit_len_in = fill_ff;
               emit_ovf_in = ovf_ff;
               oline_in    = line_inc;
               ooff_in     = off_inc;
               priority if (label_nl) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
                  idx_in          = '0;
                  seq_in          = SEQ_NAME;
               end else if (mode_ff == MODE_TILDE) begin
                  if (out_free) begin
                     out_load = 1'b1;
                     kind_in  = slls_pkg::KIND_TILDE;
                     seq_in   = SEQ_LINE;
                  end else begin
                     seq_in = SEQ_TILDE;
                  end
               end else begin
                  if (out_free) begin
                     out_load = 1'b1;
                     olast_in = 1'b1;
                  end else begin
                     seq_in = SEQ_LINE;
                  end
               end
            end
         end
         SEQ_NAME: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = slls_pkg::KIND_NAME;
               char_in  = rd_data;
               if (idx_nxt < emit_len_ff) begin
                  idx_in        = idx_nxt;
                  mem_req.rd_en = 1'b1;
               end else begin
                  seq_in = SEQ_END;
               end
            end
         end
         SEQ_END: begin
            oline_in  = line_ff;
            ooff_in   = off_ff;
            olen_in   = 6'(emit_len_ff);
            otrunc_in = emit_ovf_ff;
            kind_in   = slls_pkg::KIND_END;
            if (out_free) begin
               out_load = 1'b1;
               seq_in   = SEQ_LINE;
            end
         end
         SEQ_TILDE: begin
            oline_in = line_ff;
            ooff_in  = off_ff;
            kind_in  = slls_pkg::KIND_TILDE;
            if (out_free) begin
               out_load = 1'b1;
               seq_in   = SEQ_LINE;
            end
         end
         SEQ_LINE: begin
            oline_in = line_ff;
            ooff_in  = off_ff;
            olast_in = 1'b1;
            if (out_free) begin
               out_load = 1'b1;
               seq_in   = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TOP;
         seq_ff       <= SEQ_IDLE;
         line_ff      <= 32'd1;
         off_ff       <= 32'd0;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         emit_len_ff  <= '0;
         emit_ovf_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         seq_ff      <= seq_in;
         line_ff     <= line_in;
         off_ff      <= off_in;
         fill_ff     <= fill_in;
         ovf_ff      <= ovf_in;
         idx_ff      <= idx_in;
         emit_len_ff <= emit_len_in;
         emit_ovf_ff <= emit_ovf_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         kind_ff   <= kind_in;
         char_ff   <= char_in;
         oline_ff  <= oline_in;
         ooff_ff   <= ooff_in;
         olen_ff   <= olen_in;
         otrunc_ff <= otrunc_in;
         olast_ff  <= olast_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = kind_ff;
   assign rsp.name_char      = char_ff;
   assign rsp.line_number    = oline_ff;
   assign rsp.byte_offset    = ooff_ff;
   assign rsp.name_length    = olen_ff;
   assign rsp.name_truncated = otrunc_ff;
   assign rsp.last           = olast_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(NAME_MAX))
      else $error("name fill beyond store depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (fill_ff == CNT_W'(NAME_MAX)))
      else $error("overflow flagged with store not full");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_NAME) |-> (idx_ff < emit_len_ff))
      else $error("name read index past stored length");

   a_nl_clears: assert property (@(posedge clock) disable iff (reset)
      (acc && is_nl) |=> ((mode_ff == MODE_TOP) && (fill_ff == '0) && !ovf_ff))
      else $error("newline did not restart the line scan");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && olast_in) |=> (seq_ff == SEQ_IDLE))
      else $error("final beat loaded but sequencer not idle");

endmodule

/* design/script_label_line_scanner_unit.sv */
// a plain or tilde newline's first beat is valid right after the accept edge when the
//    output is free, a label newline's first beat later, after the name store read
// throughput: one byte per cycle; a newline holds off input until its beats are loaded
// the name store has one registered read port, one name beat per cycle unless stalled
// reset: synchronous, active high; line count to 1, offset, scan mode, decode flag cleared
module script_label_line_scanner_unit #(
   parameter int NAME_MAX = slls_pkg::NAME_MAX_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   slls_req_if.sink                    req_chan,
   slls_rsp_if.source                  rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [slls_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   // register bank: decode flag only
   logic decode_ff;
   logic csr_wr;

   // name store traffic between controller and memory
   slls_pkg::mem_req_type mem_req;
   logic [7:0]            rd_data;

   assign pready = 1'b1;
   // write lands in the access phase
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_ff <= 1'b0;
      end else if (csr_wr && (paddr[2] == slls_pkg::REG_DECODE)) begin
         decode_ff <= pwdata[0];
      end
   end

   // readback of the decode flag, zero beyond the register list
   assign prdata = (paddr[2] == slls_pkg::REG_DECODE) ? {31'd0, decode_ff} : 32'd0;

   // parser, counters, result sequencer and output beat register
   slls_ctrl #(
      .NAME_MAX (NAME_MAX)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .decode_enable (decode_ff),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .mem_req       (mem_req),
      .rd_data       (rd_data)
   );

   // label name bytes, written while scanning, read back after the newline
   slls_name_ram #(
      .NAME_MAX (NAME_MAX)
   ) u_name_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

/* bench/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NAME_MAX = slls_pkg::NAME_MAX_DEF;
   // cycles with no beat and no register access before the run is called hung
   localparam int WATCHDOG_LIMIT = 2000;

   // one result beat, fields in port order
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  name_char;
      logic [31:0] line_number;
      logic [31:0] byte_offset;
      logic [5:0]  name_length;
      logic        name_truncated;
      logic        last;
   } scan_beat_type;

   // one row of the directed table: the byte, and where the outcome is obvious, its beat
   typedef struct packed {
      logic [7:0]    data;
      logic          typed;
      scan_beat_type beat;
   } scan_row_type;

   typedef enum logic [2:0] {
      SCAN_TOP, SCAN_STAR, SCAN_NAME, SCAN_DROP, SCAN_SKIP, SCAN_TILDE
   } scan_state_type;

   localparam scan_beat_type NO_BEAT = '0;

   logic clock = 1'b0;
   logic reset;

   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [slls_pkg::CSR_AW-1:0] paddr;
   logic [31:0]                 pwdata;
   logic [31:0]                 prdata;
   logic                        pready;

   slls_req_if req_chan ();
   slls_rsp_if rsp_chan ();

   script_label_line_scanner_unit #(
      .NAME_MAX (NAME_MAX)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // scanner state as the bench sees it, reset values match the block
   // ---------------------------------------------------------------
   logic              decode_on    = 1'b0;
   scan_state_type    scan_state   = SCAN_TOP;
   logic [31:0]       line_tally   = 32'd1;
   logic [31:0]       offset_tally = 32'd0;
   logic [7:0]        label_buf [NAME_MAX];
   int unsigned       label_len    = 0;
   logic              label_cut    = 1'b0;

   scan_beat_type     byte_results [$];   // beats caused by the byte just scanned
   scan_beat_type     pending_beats [$];  // beats still owed by the block, oldest first

   int unsigned       gap_pct   = 14;     // sender idle odds per hundred
   int unsigned       stall_pct = 14;     // receiver stall odds per hundred
   int unsigned       mismatches = 0;
   int unsigned       quiet_cycles = 0;
   scan_beat_type     seen_beat;

   // directed rows: the beats of the first three newlines are typed in, the rest predicted
   scan_row_type directed_rows [22] = '{
      '{slls_pkg::CHAR_NL, 1'b1,
        '{slls_pkg::KIND_LINE, 8'h00, 32'd2, 32'd1, 6'd0, 1'b0, 1'b1}},
      '{slls_pkg::CHAR_NL, 1'b1,
        '{slls_pkg::KIND_LINE, 8'h00, 32'd3, 32'd2, 6'd0, 1'b0, 1'b1}},
      // all ones and all zeros make a plain line
      '{8'hFF,      1'b0, NO_BEAT},
      '{8'h00,      1'b0, NO_BEAT},
      '{slls_pkg::CHAR_NL, 1'b1,
        '{slls_pkg::KIND_LINE, 8'h00, 32'd4, 32'd5, 6'd0, 1'b0, 1'b1}},
      // label after leading blank, blank after the star, name cut by a later blank
      '{slls_pkg::CHAR_SPACE, 1'b0, NO_BEAT},
      '{slls_pkg::CHAR_STAR,  1'b0, NO_BEAT},
      '{slls_pkg::CHAR_TAB,   1'b0, NO_BEAT},
      '{"A",                  1'b0, NO_BEAT},
      '{"B",                  1'b0, NO_BEAT},
      '{slls_pkg::CHAR_SPACE, 1'b0, NO_BEAT},
      '{"C",                  1'b0, NO_BEAT},
      '{slls_pkg::CHAR_NL,    1'b0, NO_BEAT},
      // tilde line
      '{slls_pkg::CHAR_TILDE, 1'b0, NO_BEAT},
      '{"x",                  1'b0, NO_BEAT},
      '{slls_pkg::CHAR_NL,    1'b0, NO_BEAT},
      // star with no name: line start only
      '{slls_pkg::CHAR_STAR,  1'b0, NO_BEAT},
      '{slls_pkg::CHAR_NL,    1'b0, NO_BEAT},
      // tilde and star stored as name bytes
      '{slls_pkg::CHAR_STAR,  1'b0, NO_BEAT},
      '{slls_pkg::CHAR_TILDE, 1'b0, NO_BEAT},
      '{slls_pkg::CHAR_STAR,  1'b0, NO_BEAT},
      '{slls_pkg::CHAR_NL,    1'b0, NO_BEAT}
   };

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // ---------------------------------------------------------------
   // scan one raw byte, leave its beats in byte_results
   // ---------------------------------------------------------------
   task automatic scan_byte(input logic [7:0] raw);
      logic [7:0] c;
      logic       blank;
      byte_results.delete();
      c = decode_on ? (raw ^ slls_pkg::DECODE_KEY) : raw;
      offset_tally = bump(offset_tally);
      blank = (c == slls_pkg::CHAR_SPACE) || (c == slls_pkg::CHAR_TAB);
      if (c == slls_pkg::CHAR_NL) begin
         line_tally = bump(line_tally);
         if ((scan_state == SCAN_STAR || scan_state == SCAN_NAME ||
              scan_state == SCAN_DROP) && label_len != 0) begin
            // stored name goes out byte by byte, then the label end record
            for (int i = 0; i < label_len; i++)
               byte_results.push_back('{slls_pkg::KIND_NAME, label_buf[i], 32'd0, 32'd0,
                                        6'd0, 1'b0, 1'b0});
            byte_results.push_back('{slls_pkg::KIND_END, 8'h00, line_tally, offset_tally,
                                     6'(label_len), label_cut, 1'b0});
         end else if (scan_state == SCAN_TILDE) begin
            byte_results.push_back('{slls_pkg::KIND_TILDE, 8'h00, line_tally, offset_tally,
                                     6'd0, 1'b0, 1'b0});
         end
         // every newline closes with the line start record
         byte_results.push_back('{slls_pkg::KIND_LINE, 8'h00, line_tally, offset_tally,
                                  6'd0, 1'b0, 1'b1});
         scan_state = SCAN_TOP;
         label_len  = 0;
         label_cut  = 1'b0;
      end else begin
         case (scan_state)
            SCAN_TOP: begin
               if (!blank) begin
                  if (c == slls_pkg::CHAR_STAR) begin
                     label_len  = 0;
                     label_cut  = 1'b0;
                     scan_state = SCAN_STAR;
                  end else if (c == slls_pkg::CHAR_TILDE) begin
                     scan_state = SCAN_TILDE;
                  end else begin
                     scan_state = SCAN_SKIP;
                  end
               end
            end
            SCAN_STAR, SCAN_NAME: begin
               if (blank && scan_state == SCAN_NAME) begin
                  // a blank ends the name, the rest of the line is dropped
                  scan_state = SCAN_DROP;
               end else if (!blank) begin
                  // bytes past the store are dropped and flagged
                  if (label_len < NAME_MAX) begin
                     label_buf[label_len] = c;
                     label_len++;
                  end else begin
                     label_cut = 1'b1;
                  end
                  scan_state = SCAN_NAME;
               end
            end
            SCAN_DROP, SCAN_SKIP, SCAN_TILDE: ;
            default: scan_state = SCAN_SKIP;
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // sender: one byte per call, valid stays high between back-to-back beats
   // ---------------------------------------------------------------
   task automatic send_byte(input logic [7:0] data, input logic typed,
                            input scan_beat_type typed_beat);
      while ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.byte_in <= data;
      do @(posedge clock); while (!req_chan.ready);
      // beat taken at this edge
      scan_byte(data);
      if (typed)
         pending_beats.push_back(typed_beat);
      else
         foreach (byte_results[i]) pending_beats.push_back(byte_results[i]);
   endtask

   // stop sending and wait for every owed beat, plus settle_cycles for stragglers
   task automatic drain_results(input int unsigned settle_cycles);
      req_chan.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (settle_cycles) @(posedge clock);
   endtask

   // register write: setup cycle, then access cycle until pready
   task automatic write_decode(input logic value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= slls_pkg::CSR_AW'(4 * slls_pkg::REG_DECODE);
      pwdata  <= {31'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      decode_on = value;
   endtask

   // ---------------------------------------------------------------
   // random script text generators
   // ---------------------------------------------------------------
   function automatic logic [7:0] pick_blank();
      return $urandom_range(1) ? slls_pkg::CHAR_SPACE : slls_pkg::CHAR_TAB;
   endfunction

   // any byte but newline
   function automatic logic [7:0] pick_text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == slls_pkg::CHAR_NL);
      return b;
   endfunction

   // any byte that can sit inside a label name
   function automatic logic [7:0] pick_name_byte();
      logic [7:0] b;
      do b = pick_text_byte();
      while (b == slls_pkg::CHAR_SPACE || b == slls_pkg::CHAR_TAB);
      return b;
   endfunction

   // mostly well-formed lines with random content, the rest raw noise
   task automatic run_text_phase(input int unsigned goal, input int unsigned gap,
                                 input int unsigned stall);
      logic [7:0]  text [$];
      logic [7:0]  first;
      int unsigned sent;
      int unsigned pick;
      int unsigned name_bytes;
      gap_pct   = gap;
      stall_pct = stall;
      sent      = 0;
      while (sent < goal) begin
         text.delete();
         pick = $urandom_range(99);
         if (pick < 80) begin
            repeat ($urandom_range(2)) text.push_back(pick_blank());
            if (pick < 40) begin
               // label line, now and then a name near or past the store depth
               text.push_back(slls_pkg::CHAR_STAR);
               repeat ($urandom_range(2)) text.push_back(pick_blank());
               name_bytes = ($urandom_range(7) == 0) ?
                            $urandom_range(NAME_MAX + 8, NAME_MAX - 2) :
                            $urandom_range(8, 0);
               repeat (name_bytes) text.push_back(pick_name_byte());
               if ($urandom_range(1)) begin
                  text.push_back(pick_blank());
                  repeat ($urandom_range(3)) text.push_back(pick_text_byte());
               end
            end else if (pick < 55) begin
               text.push_back(slls_pkg::CHAR_TILDE);
               repeat ($urandom_range(3)) text.push_back(pick_text_byte());
            end else if (pick < 70) begin
               // plain line
               do first = pick_name_byte();
               while (first == slls_pkg::CHAR_STAR || first == slls_pkg::CHAR_TILDE);
               text.push_back(first);
               repeat ($urandom_range(4)) text.push_back(pick_text_byte());
            end
            text.push_back(slls_pkg::CHAR_NL);
            // encode so the block sees the intended text after decoding
            if (decode_on)
               foreach (text[i]) text[i] = text[i] ^ slls_pkg::DECODE_KEY;
         end else begin
            repeat ($urandom_range(6, 1)) text.push_back(8'($urandom_range(255)));
         end
         foreach (text[i]) send_byte(text[i], 1'b0, NO_BEAT);
         sent += text.size();
      end
   endtask

   // ---------------------------------------------------------------
   // result side: random stalls, every beat checked against the oldest owed one
   // ---------------------------------------------------------------
   task automatic check_beat(input scan_beat_type got, input scan_beat_type want);
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, got.kind);
         mismatches++;
      end
      if (got.name_char !== want.name_char) begin
         $error("name_char: expected %0h, got %0h", want.name_char, got.name_char);
         mismatches++;
      end
      if (got.line_number !== want.line_number) begin
         $error("line_number: expected %0d, got %0d", want.line_number, got.line_number);
         mismatches++;
      end
      if (got.byte_offset !== want.byte_offset) begin
         $error("byte_offset: expected %0d, got %0d", want.byte_offset, got.byte_offset);
         mismatches++;
      end
      if (got.name_length !== want.name_length) begin
         $error("name_length: expected %0d, got %0d", want.name_length, got.name_length);
         mismatches++;
      end
      if (got.name_truncated !== want.name_truncated) begin
         $error("name_truncated: expected %0b, got %0b", want.name_truncated,
                got.name_truncated);
         mismatches++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, got.last);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_chan.ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen_beat = '{rsp_chan.kind, rsp_chan.name_char, rsp_chan.line_number,
                       rsp_chan.byte_offset, rsp_chan.name_length,
                       rsp_chan.name_truncated, rsp_chan.last};
         if (pending_beats.size() == 0) begin
            $error("kind: expected no beat, got %0d", seen_beat.kind);
            mismatches++;
         end else begin
            check_beat(seen_beat, pending_beats.pop_front());
         end
      end
   end

   // watchdog on cycles with no beat and no register access
   always @(posedge clock) begin
      if (reset || psel || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // run sequence
   // ---------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.byte_in <= 8'h00;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= 32'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table with decoding off
      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].beat);
      drain_results(4);

      // decoding on, idling on both sides
      write_decode(1'b1);
      run_text_phase(60, 14, 14);
      drain_results(4);

      // decoding off, a stretch with no idling at all
      write_decode(1'b0);
      run_text_phase(60, 0, 0);
      drain_results(4);

      write_decode(1'b1);
      run_text_phase(60, 14, 14);
      drain_results(4);

      write_decode(1'b0);
      run_text_phase(60, 14, 14);
      // label cut off by the end of input: nothing may come out
      send_byte(slls_pkg::CHAR_STAR, 1'b0, NO_BEAT);
      send_byte("a", 1'b0, NO_BEAT);
      send_byte("b", 1'b0, NO_BEAT);
      drain_results(16);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* filelist.f */
design/slls_pkg.sv
design/slls_if.sv
design/slls_name_ram.sv
design/slls_ctrl.sv
design/script_label_line_scanner_unit.sv
bench/testbench.sv
